@@ rtl/pdsd_pkg.sv @@
// ----------------------------------------------------------------------------
// pdsd_pkg
// Shared widths, constants and types of the two-channel deadband scaler.
// ----------------------------------------------------------------------------
package pdsd_pkg;

  localparam int SampleBits    = 10;
  localparam int ValueBits     = 7;
  localparam int DigitBits     = 4;
  localparam int ProdBits      = SampleBits + ValueBits;
  localparam int StepBits      = $clog2(ValueBits);
  localparam int CfgIdxBits    = 3;
  localparam int CfgDataBits   = 10;
  localparam int TdataInBits   = ((2 * SampleBits + 7) / 8) * 8;
  localparam int OutFieldBits  = 2 * ValueBits + 4 * DigitBits + 3;
  localparam int TdataOutBits  = ((OutFieldBits + 7) / 8) * 8;

  localparam logic [ValueBits-1:0]  ScaleTop      = ValueBits'(99);
  localparam logic [SampleBits-1:0] TriggerMargin = SampleBits'(8);
  localparam logic [SampleBits-1:0] FullScaleRst  = SampleBits'(868);
  localparam logic [ValueBits-1:0]  TargetARst    = ValueBits'(55);
  localparam logic [ValueBits-1:0]  TargetBRst    = ValueBits'(96);
  localparam logic [SampleBits-1:0] NoiseBandRst  = SampleBits'(3);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_FULL_SCALE_A = 3'd0,
    CFG_FULL_SCALE_B = 3'd1,
    CFG_TARGET_A     = 3'd2,
    CFG_TARGET_B     = 3'd3,
    CFG_NOISE_BAND   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                 idle;
    logic                 done;
    logic [ValueBits-1:0] value;
  } lane_status_t;

endpackage

@@ rtl/pdsd_lane.sv @@
// ----------------------------------------------------------------------------
// pdsd_lane
// One channel: deadband filter on the raw sample, clamp to full scale, then a
// restoring divide of stable*99 by full scale, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdsd_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              ack_i,
  input  logic [pdsd_pkg::SampleBits-1:0]   sample_i,
  input  logic [pdsd_pkg::SampleBits-1:0]   full_scale_i,
  input  logic [pdsd_pkg::SampleBits-1:0]   noise_band_i,
  output pdsd_pkg::lane_status_t            status_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_DIV,
    L_DONE
  } lane_state_e;

  localparam logic [pdsd_pkg::StepBits-1:0] StepTop =
    pdsd_pkg::StepBits'(pdsd_pkg::ValueBits - 1);

  lane_state_e                          state_q;
  logic [pdsd_pkg::SampleBits-1:0]      stable_q;
  logic [pdsd_pkg::SampleBits-1:0]      div_q;
  logic [pdsd_pkg::ProdBits-1:0]        rem_q;
  logic [pdsd_pkg::ValueBits-1:0]       quo_q;
  logic [pdsd_pkg::StepBits-1:0]        step_q;
  logic                                 zero_q;

  logic [pdsd_pkg::SampleBits-1:0]      diff;
  logic [pdsd_pkg::SampleBits-1:0]      limit;
  logic                                 take;
  logic [pdsd_pkg::SampleBits-1:0]      cand;
  logic [pdsd_pkg::SampleBits-1:0]      stable_d;
  logic [pdsd_pkg::ProdBits-1:0]        product;
  logic [pdsd_pkg::ProdBits-1:0]        trial;

  always_comb begin
    diff  = (sample_i >= stable_q) ? (sample_i - stable_q) : (stable_q - sample_i);
    limit = (full_scale_i > pdsd_pkg::TriggerMargin) ?
            (full_scale_i - pdsd_pkg::TriggerMargin) : '0;
    take  = (diff > noise_band_i) || (sample_i == '0) || (sample_i > limit);
    cand  = take ? sample_i : stable_q;
    stable_d = (cand > full_scale_i) ? full_scale_i : cand;
    product  = pdsd_pkg::ProdBits'(stable_d) * pdsd_pkg::ProdBits'(pdsd_pkg::ScaleTop);
    trial    = pdsd_pkg::ProdBits'(div_q) << step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      stable_q <= '0;
      div_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      step_q   <= '0;
      zero_q   <= 1'b0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            stable_q <= stable_d;
            rem_q    <= product;
            div_q    <= full_scale_i;
            zero_q   <= (full_scale_i == '0);
            quo_q    <= '0;
            step_q   <= StepTop;
            state_q  <= L_DIV;
          end
        end
        L_DIV: begin
          if (rem_q >= trial) begin
            rem_q <= rem_q - trial;
            quo_q <= quo_q | (pdsd_pkg::ValueBits'(1) << step_q);
          end
          if (step_q == '0) begin
            state_q <= L_DONE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        L_DONE: begin
          if (ack_i) begin
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign status_o.idle  = (state_q == L_IDLE);
  assign status_o.done  = (state_q == L_DONE);
  assign status_o.value = zero_q ? '0 : quo_q;

endmodule

@@ rtl/pdsd_merge.sv @@
// ----------------------------------------------------------------------------
// pdsd_merge
// Combine both lane results: digit split, target matches, and the output
// register of the result stream.
// ----------------------------------------------------------------------------
module pdsd_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [pdsd_pkg::ValueBits-1:0]      value_a_i,
  input  logic [pdsd_pkg::ValueBits-1:0]      value_b_i,
  input  logic [pdsd_pkg::ValueBits-1:0]      target_a_i,
  input  logic [pdsd_pkg::ValueBits-1:0]      target_b_i,
  output logic                                free_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pdsd_pkg::TdataOutBits-1:0]   m_axis_tdata
);

  localparam int MulBits = pdsd_pkg::ValueBits + 8;

  logic [MulBits-1:0]                   tens_prod_a;
  logic [MulBits-1:0]                   tens_prod_b;
  logic [pdsd_pkg::DigitBits-1:0]       tens_a;
  logic [pdsd_pkg::DigitBits-1:0]       tens_b;
  logic [pdsd_pkg::ValueBits-1:0]       ones_full_a;
  logic [pdsd_pkg::ValueBits-1:0]       ones_full_b;
  logic                                 match_a;
  logic                                 match_b;
  logic [pdsd_pkg::TdataOutBits-1:0]    tdata_d;
  logic [pdsd_pkg::TdataOutBits-1:0]    tdata_q;
  logic                                 valid_q;

  // divide by ten as multiply by 205 and shift by 11
  always_comb begin
    tens_prod_a = MulBits'(value_a_i) * MulBits'(205);
    tens_prod_b = MulBits'(value_b_i) * MulBits'(205);
    tens_a      = tens_prod_a[14:11];
    tens_b      = tens_prod_b[14:11];
    ones_full_a = value_a_i - pdsd_pkg::ValueBits'(tens_a) * pdsd_pkg::ValueBits'(10);
    ones_full_b = value_b_i - pdsd_pkg::ValueBits'(tens_b) * pdsd_pkg::ValueBits'(10);
    match_a     = (value_a_i == target_a_i);
    match_b     = (value_b_i == target_b_i);
    tdata_d = pdsd_pkg::TdataOutBits'({match_a & match_b, match_b, match_a,
                                       ones_full_b[pdsd_pkg::DigitBits-1:0], tens_b,
                                       ones_full_a[pdsd_pkg::DigitBits-1:0], tens_a,
                                       value_b_i, value_a_i});
  end

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tdata_q <= '0;
    end else begin
      if (load_i) begin
        valid_q <= 1'b1;
        tdata_q <= tdata_d;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = tdata_q;

endmodule

@@ rtl/pot_deadband_scale_digits_top.sv @@
// ----------------------------------------------------------------------------
// pot_deadband_scale_digits_top
// Two potentiometer channels: deadband filter, scale to 0..99, digit split
// and target match.
// A request is taken while the lanes are idle, run through the 7-step restoring
// divider in each lane and then loaded into the output register; no new request
// is taken until that load, but one is taken while a result waits at the output.
// Reset: stable values clear to zero, registers return to their defaults.
// ----------------------------------------------------------------------------
module pot_deadband_scale_digits_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pdsd_pkg::TdataInBits-1:0]    s_axis_tdata,   // sample_a, sample_b
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // value_a, value_b, tens_a, ones_a, tens_b, ones_b, match_a, match_b, both_match
  output logic [pdsd_pkg::TdataOutBits-1:0]   m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdsd_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [pdsd_pkg::CfgDataBits-1:0]    cfg_data_i
);

  logic [pdsd_pkg::SampleBits-1:0]  full_scale_a_q;
  logic [pdsd_pkg::SampleBits-1:0]  full_scale_b_q;
  logic [pdsd_pkg::ValueBits-1:0]   target_a_q;
  logic [pdsd_pkg::ValueBits-1:0]   target_b_q;
  logic [pdsd_pkg::SampleBits-1:0]  noise_band_q;

  pdsd_pkg::lane_status_t           status_a;
  pdsd_pkg::lane_status_t           status_b;
  logic                             start;
  logic                             load;
  logic                             free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_a_q <= pdsd_pkg::FullScaleRst;
      full_scale_b_q <= pdsd_pkg::FullScaleRst;
      target_a_q     <= pdsd_pkg::TargetARst;
      target_b_q     <= pdsd_pkg::TargetBRst;
      noise_band_q   <= pdsd_pkg::NoiseBandRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pdsd_pkg::CFG_FULL_SCALE_A: full_scale_a_q <= cfg_data_i[pdsd_pkg::SampleBits-1:0];
        pdsd_pkg::CFG_FULL_SCALE_B: full_scale_b_q <= cfg_data_i[pdsd_pkg::SampleBits-1:0];
        pdsd_pkg::CFG_TARGET_A:     target_a_q     <= cfg_data_i[pdsd_pkg::ValueBits-1:0];
        pdsd_pkg::CFG_TARGET_B:     target_b_q     <= cfg_data_i[pdsd_pkg::ValueBits-1:0];
        pdsd_pkg::CFG_NOISE_BAND:   noise_band_q   <= cfg_data_i[pdsd_pkg::SampleBits-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = status_a.idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign load          = status_a.done && free;

  pdsd_lane u_lane_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .ack_i        (load),
    .sample_i     (s_axis_tdata[pdsd_pkg::SampleBits-1:0]),
    .full_scale_i (full_scale_a_q),
    .noise_band_i (noise_band_q),
    .status_o     (status_a)
  );

  pdsd_lane u_lane_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .ack_i        (load),
    .sample_i     (s_axis_tdata[2*pdsd_pkg::SampleBits-1:pdsd_pkg::SampleBits]),
    .full_scale_i (full_scale_b_q),
    .noise_band_i (noise_band_q),
    .status_o     (status_b)
  );

  pdsd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load && status_b.done),
    .value_a_i     (status_a.value),
    .value_b_i     (status_b.value),
    .target_a_i    (target_a_q),
    .target_b_i    (target_b_q),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-channel deadband scaler. A directed table
// covers reset state, field extremes, tiny and zero full scale, unreachable
// targets and unused register indexes. Random phases follow, all but the first
// with fresh register settings. Each accepted request runs through a local model
// of the deadband, clamp, scale and digit logic; every result is compared field
// by field against the oldest expected entry (typed rows give their own).
// ----------------------------------------------------------------------------
module testbench;
  import pdsd_pkg::*;

  localparam int QuietLimit  = 3000;
  localparam int DrainCycles = 32;
  localparam int LongHold    = 400;
  localparam int HoldAfter   = 600;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 142;

  localparam logic [CfgIdxBits-1:0] IdxSpare5 = 3'd5;
  localparam logic [CfgIdxBits-1:0] IdxSpare6 = 3'd6;
  localparam logic [CfgIdxBits-1:0] IdxSpare7 = 3'd7;

  typedef struct packed {
    logic                 both_match;
    logic                 match_b;
    logic                 match_a;
    logic [DigitBits-1:0] ones_b;
    logic [DigitBits-1:0] tens_b;
    logic [DigitBits-1:0] ones_a;
    logic [DigitBits-1:0] tens_a;
    logic [ValueBits-1:0] value_b;
    logic [ValueBits-1:0] value_a;
  } digits_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxBits-1:0] idx;
    logic [SampleBits-1:0] a;
    logic [SampleBits-1:0] b;
    logic [ValueBits-1:0]  va;
    logic [ValueBits-1:0]  vb;
    logic                  ma;
    logic                  mb;
  } stim_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_LIGHT, SINK_HEAVY} sink_mode_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [TdataInBits-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [TdataOutBits-1:0] m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxBits-1:0]   cfg_index_i = '0;
  logic [CfgDataBits-1:0]  cfg_data_i = '0;

  logic [SampleBits-1:0] cur_full_scale [2];
  logic [ValueBits-1:0]  cur_target [2];
  logic [SampleBits-1:0] cur_band;
  logic [SampleBits-1:0] held_raw [2];

  digits_t    digits_due [$];
  stim_row_t  directed_rows [$];
  int         mismatch_count = 0;
  int         samples_taken = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  int         mode_left = 0;
  bit         long_hold_done = 1'b0;
  sink_mode_e sink_mode = SINK_OPEN;

  pot_deadband_scale_digits_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ValueBits-1:0] scale_channel(input int ch,
                                                         input logic [SampleBits-1:0] smp);
    logic [SampleBits-1:0] kept;
    logic [SampleBits-1:0] fs;
    logic [SampleBits-1:0] diff;
    logic [SampleBits-1:0] limit;
    kept  = held_raw[ch];
    fs    = cur_full_scale[ch];
    diff  = (smp >= kept) ? smp - kept : kept - smp;
    limit = (fs > TriggerMargin) ? fs - TriggerMargin : '0;
    if (diff > cur_band || smp == '0 || smp > limit) kept = smp;
    if (kept > fs) kept = fs;
    held_raw[ch] = kept;
    if (fs == '0) return '0;
    return ValueBits'((32'(kept) * 32'(ScaleTop)) / 32'(fs));
  endfunction

  function automatic digits_t pack_result(input logic [ValueBits-1:0] va,
                                          input logic [ValueBits-1:0] vb,
                                          input logic ma, input logic mb);
    digits_t r;
    r.value_a    = va;
    r.value_b    = vb;
    r.tens_a     = DigitBits'((va / 10) % 10);
    r.ones_a     = DigitBits'(va % 10);
    r.tens_b     = DigitBits'((vb / 10) % 10);
    r.ones_b     = DigitBits'(vb % 10);
    r.match_a    = ma;
    r.match_b    = mb;
    r.both_match = ma & mb;
    return r;
  endfunction

  function automatic digits_t predict_digits(input logic [SampleBits-1:0] a,
                                             input logic [SampleBits-1:0] b);
    logic [ValueBits-1:0] va;
    logic [ValueBits-1:0] vb;
    va = scale_channel(0, a);
    vb = scale_channel(1, b);
    return pack_result(va, vb, va == cur_target[0], vb == cur_target[1]);
  endfunction

  function automatic logic [SampleBits-1:0] pick_sample(input int ch);
    int fs;
    int lo;
    int span;
    int v;
    fs = int'(cur_full_scale[ch]);
    lo = (fs > 8) ? fs - 8 : 0;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = lo + int'($urandom_range(0, 12));
      2: begin
        if (fs == 0) v = int'($urandom_range(0, 1023));
        else v = (int'(cur_target[ch]) * fs + 98) / 99 + int'($urandom_range(0, 2)) - 1;
      end
      3, 4, 5: begin
        span = int'(cur_band) + 2;
        v = int'(held_raw[ch]) + int'($urandom_range(0, 2 * span)) - span;
      end
      default: v = int'($urandom_range(0, 1023));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SampleBits-1:0];
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_full_scale();
    case ($urandom_range(0, 7))
      0: return CfgDataBits'(9);
      1: return CfgDataBits'(1023);
      2: return CfgDataBits'($urandom_range(0, 8));
      3: return FullScaleRst;
      default: return CfgDataBits'($urandom_range(9, 1023));
    endcase
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_target();
    case ($urandom_range(0, 5))
      0: return CfgDataBits'($urandom_range(100, 127));
      1: return CfgDataBits'($urandom_range(0, 1023));
      default: return CfgDataBits'($urandom_range(0, 99));
    endcase
  endfunction

  function automatic void add_sample(input logic [SampleBits-1:0] a,
                                     input logic [SampleBits-1:0] b);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.a = a;
    r.b = b;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_typed(input logic [SampleBits-1:0] a,
                                    input logic [SampleBits-1:0] b,
                                    input logic [ValueBits-1:0] va,
                                    input logic [ValueBits-1:0] vb,
                                    input logic ma, input logic mb);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TYPED;
    r.a = a;
    r.b = b;
    r.va = va;
    r.vb = vb;
    r.ma = ma;
    r.mb = mb;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CfgIdxBits-1:0] idx,
                                  input logic [CfgDataBits-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.a = data;
    directed_rows.push_back(r);
  endfunction

  task automatic report_mismatch(input string text);
    if (mismatch_count < 60) $display("ERROR %0t: %s", $time, text);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [9:0] got,
                             input logic [9:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic send_sample(input logic [SampleBits-1:0] a,
                             input logic [SampleBits-1:0] b,
                             input logic typed, input digits_t typed_want);
    digits_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TdataInBits'({b, a});
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_digits(a, b);
    digits_due.push_back(typed ? typed_want : predicted);
    samples_taken++;
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FULL_SCALE_A: cur_full_scale[0] = data;
      CFG_FULL_SCALE_B: cur_full_scale[1] = data;
      CFG_TARGET_A:     cur_target[0] = data[ValueBits-1:0];
      CFG_TARGET_B:     cur_target[1] = data[ValueBits-1:0];
      CFG_NOISE_BAND:   cur_band = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : sink_pacing
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && samples_taken >= HoldAfter) begin
      long_hold_done = 1'b1;
      hold_left = LongHold;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (sink_mode)
        SINK_OPEN:  m_axis_tready <= 1'b1;
        SINK_HALF:  m_axis_tready <= 1'($urandom_range(0, 1));
        SINK_LIGHT: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default:    m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    digits_t got;
    digits_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OutFieldBits-1:0];
      if (digits_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = digits_due.pop_front();
        check_field("value_a", 10'(got.value_a), 10'(want.value_a));
        check_field("value_b", 10'(got.value_b), 10'(want.value_b));
        check_field("tens_a", 10'(got.tens_a), 10'(want.tens_a));
        check_field("ones_a", 10'(got.ones_a), 10'(want.ones_a));
        check_field("tens_b", 10'(got.tens_b), 10'(want.tens_b));
        check_field("ones_b", 10'(got.ones_b), 10'(want.ones_b));
        check_field("match_a", 10'(got.match_a), 10'(want.match_a));
        check_field("match_b", 10'(got.match_b), 10'(want.match_b));
        check_field("both_match", 10'(got.both_match), 10'(want.both_match));
        check_field("pad", 10'(m_axis_tdata[TdataOutBits-1:OutFieldBits]), '0);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    bit        cfg_open;
    int        burst;
    int        gap;
    int        sent;
    cur_full_scale[0] = FullScaleRst;
    cur_full_scale[1] = FullScaleRst;
    cur_target[0]     = TargetARst;
    cur_target[1]     = TargetBRst;
    cur_band          = NoiseBandRst;
    held_raw[0]       = '0;
    held_raw[1]       = '0;
    cfg_open          = 1'b0;

    add_typed(10'd0, 10'd0, 7'd0, 7'd0, 1'b0, 1'b0);
    add_typed(10'd1023, 10'd1023, 7'd99, 7'd99, 1'b0, 1'b0);
    add_typed(10'd868, 10'd868, 7'd99, 7'd99, 1'b0, 1'b0);
    add_sample(10'd483, 10'd842);
    add_sample(10'd485, 10'd843);
    add_sample(10'd487, 10'd846);
    add_typed(10'd0, 10'd0, 7'd0, 7'd0, 1'b0, 1'b0);
    add_sample(10'd2, 10'd3);
    add_sample(10'd1, 10'd1022);
    // zero and tiny full scale, widest band, unreachable target
    add_cfg(CFG_FULL_SCALE_A, 10'd0);
    add_cfg(CFG_FULL_SCALE_B, 10'd5);
    add_cfg(CFG_NOISE_BAND, 10'd1023);
    add_cfg(CFG_TARGET_A, 10'h3FF);
    add_cfg(CFG_TARGET_B, 10'd0);
    add_cfg(IdxSpare5, 10'd1);
    add_cfg(IdxSpare6, 10'h3FF);
    add_cfg(IdxSpare7, 10'h2AA);
    add_typed(10'd1023, 10'd0, 7'd0, 7'd0, 1'b0, 1'b1);
    add_sample(10'd500, 10'd3);
    add_sample(10'd7, 10'd6);
    add_sample(10'd1, 10'd1023);
    add_cfg(CFG_FULL_SCALE_A, 10'd1023);
    add_cfg(CFG_FULL_SCALE_B, 10'd9);
    add_cfg(CFG_NOISE_BAND, 10'd0);
    add_cfg(CFG_TARGET_A, 10'd99);
    add_cfg(CFG_TARGET_B, 10'd99);
    add_typed(10'd1023, 10'd1023, 7'd99, 7'd99, 1'b1, 1'b1);
    add_sample(10'd512, 10'd1);
    add_sample(10'd513, 10'd2);
    add_sample(10'd513, 10'd513);
    add_sample(10'd0, 10'd9);
    add_cfg(CFG_FULL_SCALE_A, FullScaleRst);
    add_cfg(CFG_FULL_SCALE_B, FullScaleRst);
    add_cfg(CFG_TARGET_A, 10'(TargetARst));
    add_cfg(CFG_TARGET_B, 10'(TargetBRst));
    add_cfg(CFG_NOISE_BAND, NoiseBandRst);
    add_sample(10'h2AA, 10'h155);
    add_sample(10'h155, 10'h2AA);
    add_sample(10'd483, 10'd842);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) wait_drained();
        write_reg(row.idx, row.a);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid_i <= 1'b0;
        cfg_open = 1'b0;
        send_sample(row.a, row.b, row.kind == ROW_TYPED,
                    pack_result(row.va, row.vb, row.ma, row.mb));
      end
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_drained();
      if (phase != 0) begin
        write_reg(CFG_FULL_SCALE_A, pick_full_scale());
        write_reg(CFG_FULL_SCALE_B, pick_full_scale());
        write_reg(CFG_TARGET_A, pick_target());
        write_reg(CFG_TARGET_B, pick_target());
        case ($urandom_range(0, 4))
          0: write_reg(CFG_NOISE_BAND, '0);
          1: write_reg(CFG_NOISE_BAND, 10'd1023);
          2: write_reg(CFG_NOISE_BAND, CfgDataBits'($urandom_range(0, 1023)));
          default: write_reg(CFG_NOISE_BAND, CfgDataBits'($urandom_range(0, 12)));
        endcase
        if ($urandom_range(0, 2) == 0)
          write_reg(CfgIdxBits'($urandom_range(IdxSpare5, IdxSpare7)),
                    CfgDataBits'($urandom_range(0, 1023)));
        cfg_valid_i <= 1'b0;
      end
      sent = 0;
      while (sent < PhaseItems) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst && sent < PhaseItems; k++) begin
          send_sample(pick_sample(0), pick_sample(1), 1'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
